// ===== hw/rtl/lbpt_pkg.sv =====
// Shared types and constants for the LED blink pattern timer.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package lbpt_pkg;

  localparam int NUM_LEDS_DEFAULT = 3;
  localparam int SLOTS            = 3;

  localparam int GAP_W    = 16;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 2;
  localparam int LEVELS_W = 3;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int NUM_REGS = 2 * SLOTS;
  localparam int REG_IDX_W = 3;

  // Low bit of a register index picks the field of a slot.
  localparam logic REG_SEL_MODE = 1'b0;
  localparam logic REG_SEL_GAP  = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OVER   = 2'd3;

  localparam logic [GAP_W-1:0] DEFAULT_GAP0   = 16'd300;
  localparam logic [GAP_W-1:0] TEMP_GAP_RESET = 16'd50;

  typedef struct packed {
    logic               opcode;
    logic [INDEX_W-1:0] led_index;
    logic [GAP_W-1:0]   gap_ticks;
    logic [MODE_W-1:0]  pattern_mode;
    logic [COUNT_W-1:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [GAP_W-1:0]  gap;
  } led_cfg_t;

endpackage

// ===== hw/rtl/lbpt_item_if.sv =====
// Input channel of the LED blink pattern timer: valid/ready plus one command.
// Depends on lbpt_pkg for field widths.
`timescale 1ns / 1ps

interface lbpt_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [lbpt_pkg::INDEX_W-1:0] led_index;
  logic [lbpt_pkg::GAP_W-1:0]   gap_ticks;
  logic [lbpt_pkg::MODE_W-1:0]  pattern_mode;
  logic [lbpt_pkg::COUNT_W-1:0] repeat_count;

  modport source (output valid, opcode, led_index, gap_ticks, pattern_mode, repeat_count,
                  input ready);
  modport sink (input valid, opcode, led_index, gap_ticks, pattern_mode, repeat_count,
                output ready);
endinterface

// ===== hw/rtl/lbpt_result_if.sv =====
// Output channel of the LED blink pattern timer: valid/ready plus LED levels.
// Depends on lbpt_pkg for field widths.
`timescale 1ns / 1ps

interface lbpt_result_if;
  logic                          valid;
  logic                          ready;
  logic [lbpt_pkg::LEVELS_W-1:0] led_levels;

  modport source (output valid, led_levels, input ready);
  modport sink (input valid, led_levels, output ready);
endinterface

// ===== hw/rtl/led_blink_pattern_timer_top.sv =====
// Top level of the LED blink pattern timer: input register, LED slots, result register.
// Depends on lbpt_pkg, lbpt_item_if, lbpt_result_if, lbpt_cfg_regs and lbpt_led_slot.
`timescale 1ns / 1ps

// Usage:
//   item   - command channel. opcode tick advances every LED countdown; opcode load
//            sets the temporary gap, mode and repeat count of the LED at led_index
//            (an index past the last LED is ignored).
//   result - one transfer per command, carrying the LED levels after that command.
//   APB    - default mode and gap of each LED at byte address 8*led (mode) and
//            8*led+4 (gap). Write only while no command is in flight.
// Flow: an accepted command waits in the input register; once the result register is
// free, it is applied to the LED slots and its levels are loaded into the result register.
// One command per cycle is sustained while the receiver takes every result; the rate is
// set by the input register and the result register, with the per-LED decrement and mode select between them.
// Reset (synchronous, rst high): countdowns 0, LEDs dark, temporary mode toggle with
// gap 50 and no repeats, LED 0 default toggle with a reload gap of 300 ticks, others off.
// When the receiver stalls, the result is held, one more command waits in the input
// register, and item.ready drops until the result is taken.
module led_blink_pattern_timer_top #(
  parameter int NUM_LEDS = lbpt_pkg::NUM_LEDS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  lbpt_item_if.sink                   item,
  lbpt_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbpt_pkg::ADDR_W-1:0] paddr,
  input  logic [lbpt_pkg::DATA_W-1:0] pwdata,
  output logic [lbpt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  lbpt_pkg::item_t            item_q;
  logic                       item_valid;
  logic                       advance;
  logic                       res_valid;
  logic [lbpt_pkg::LEVELS_W-1:0] res_levels;
  logic [NUM_LEDS-1:0]        lit_next;
  lbpt_pkg::led_cfg_t         dflt [lbpt_pkg::SLOTS];

  assign advance    = item_valid && (!res_valid || result.ready);
  assign item.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.opcode       <= item.opcode;
      item_q.led_index    <= item.led_index;
      item_q.gap_ticks    <= item.gap_ticks;
      item_q.pattern_mode <= item.pattern_mode;
      item_q.repeat_count <= item.repeat_count;
    end
  end

  lbpt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dflt    (dflt)
  );

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    lbpt_led_slot u_slot (
      .clk      (clk),
      .rst      (rst),
      .step     (advance),
      .item     (item_q),
      .load_hit (item_q.led_index == lbpt_pkg::INDEX_W'(i)),
      .dflt     (dflt[i]),
      .lit_next (lit_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_levels <= lbpt_pkg::LEVELS_W'(lit_next);
    end
  end

  assign result.valid      = res_valid;
  assign result.led_levels = res_levels;

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> item.ready)
    else $error("input stalled while result register is free");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("applied command left no result");

  a_held_command_kept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid)
    else $error("waiting command dropped");

  a_unused_levels_dark: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_levels >> NUM_LEDS) == '0)
    else $error("level bit set for a missing LED");

endmodule

// ===== hw/rtl/lbpt_cfg_regs.sv =====
// APB-style register file holding the default mode and gap of each LED.
// Depends on lbpt_pkg.
`timescale 1ns / 1ps

module lbpt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbpt_pkg::ADDR_W-1:0] paddr,
  input  logic [lbpt_pkg::DATA_W-1:0] pwdata,
  output logic [lbpt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output lbpt_pkg::led_cfg_t          dflt [lbpt_pkg::SLOTS]
);

  logic [lbpt_pkg::REG_IDX_W-1:0] reg_idx;
  logic [lbpt_pkg::REG_IDX_W-2:0] slot;
  logic                           in_range;
  logic                           wr_en;

  assign reg_idx  = paddr[lbpt_pkg::ADDR_W-1:2];
  assign slot     = reg_idx[lbpt_pkg::REG_IDX_W-1:1];
  assign in_range = 32'(reg_idx) < lbpt_pkg::NUM_REGS;
  assign wr_en    = psel && penable && pwrite && pready && in_range;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbpt_pkg::SLOTS; i++) begin
        if (i == 0) begin
          dflt[i].mode <= lbpt_pkg::MODE_TOGGLE;
          dflt[i].gap  <= lbpt_pkg::DEFAULT_GAP0;
        end else begin
          dflt[i].mode <= lbpt_pkg::MODE_OFF;
          dflt[i].gap  <= '0;
        end
      end
    end else if (wr_en) begin
      if (reg_idx[0] == lbpt_pkg::REG_SEL_MODE) begin
        dflt[slot].mode <= pwdata[lbpt_pkg::MODE_W-1:0];
      end else begin
        dflt[slot].gap <= pwdata[lbpt_pkg::GAP_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (in_range) begin
      if (reg_idx[0] == lbpt_pkg::REG_SEL_GAP) begin
        prdata = lbpt_pkg::DATA_W'(dflt[slot].gap);
      end else begin
        prdata = lbpt_pkg::DATA_W'(dflt[slot].mode);
      end
    end
  end

endmodule

// ===== hw/rtl/lbpt_led_slot.sv =====
// State and step logic of one LED: countdown, temporary pattern and level.
// Depends on lbpt_pkg.
`timescale 1ns / 1ps

module lbpt_led_slot (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  lbpt_pkg::item_t    item,
  input  logic               load_hit,
  input  lbpt_pkg::led_cfg_t dflt,
  output logic               lit_next
);

  logic [lbpt_pkg::GAP_W-1:0]   countdown, countdown_next;
  logic [lbpt_pkg::MODE_W-1:0]  temp_mode, temp_mode_next;
  logic [lbpt_pkg::COUNT_W-1:0] temp_count, temp_count_next;
  logic [lbpt_pkg::GAP_W-1:0]   temp_gap, temp_gap_next;
  logic                         lit;
  logic                         use_temp;
  logic [lbpt_pkg::MODE_W-1:0]  act_mode;

  assign use_temp = temp_count != '0;
  assign act_mode = use_temp ? temp_mode : dflt.mode;

  always_comb begin
    countdown_next  = countdown;
    temp_mode_next  = temp_mode;
    temp_count_next = temp_count;
    temp_gap_next   = temp_gap;
    lit_next        = lit;
    if (step) begin
      if (item.opcode == lbpt_pkg::OP_LOAD) begin
        if (load_hit) begin
          temp_gap_next   = item.gap_ticks;
          temp_mode_next  = item.pattern_mode;
          temp_count_next = item.repeat_count;
        end
      end else if (countdown != '0) begin
        countdown_next = countdown - 16'd1;
      end else begin
        countdown_next = use_temp ? temp_gap : dflt.gap;
        if (use_temp) begin
          temp_count_next = temp_count - 8'd1;
        end
        case (act_mode)
          lbpt_pkg::MODE_OFF:    lit_next = 1'b0;
          lbpt_pkg::MODE_ON:     lit_next = 1'b1;
          lbpt_pkg::MODE_TOGGLE: lit_next = ~lit;
          default: begin
            // over: act only while the temporary mode is over, then clear it
            if (temp_mode == lbpt_pkg::MODE_OVER) begin
              lit_next       = ~lit;
              temp_mode_next = lbpt_pkg::MODE_OFF;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown  <= '0;
      temp_mode  <= lbpt_pkg::MODE_TOGGLE;
      temp_count <= '0;
      temp_gap   <= lbpt_pkg::TEMP_GAP_RESET;
      lit        <= 1'b0;
    end else begin
      countdown  <= countdown_next;
      temp_mode  <= temp_mode_next;
      temp_count <= temp_count_next;
      temp_gap   <= temp_gap_next;
      lit        <= lit_next;
    end
  end

endmodule

// ===== bench/lbpt_checker.sv =====
// Scoreboard for the LED blink pattern timer: tracks APB writes and command transfers,
// predicts the LED levels of every command and compares them with the result channel.
// Depends on lbpt_pkg, lbpt_item_if and lbpt_result_if.
`timescale 1ns / 1ps

module lbpt_checker (
  input  logic                        clk,
  input  logic                        rst,
  lbpt_item_if                        item,
  lbpt_result_if                      result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lbpt_pkg::ADDR_W-1:0] paddr,
  input  logic [lbpt_pkg::DATA_W-1:0] pwdata,
  output int                          errors,
  output int                          pending
);
  import lbpt_pkg::*;

  localparam int NL = NUM_LEDS_DEFAULT;

  led_cfg_t           led_cfg    [SLOTS];
  logic [GAP_W-1:0]   countdown  [NL];
  logic [GAP_W-1:0]   temp_gap   [NL];
  logic [MODE_W-1:0]  temp_mode  [NL];
  logic [COUNT_W-1:0] temp_count [NL];
  logic               lit        [NL];

  logic [LEVELS_W-1:0] levels_due [$];

  function automatic void clear_led_state();
    for (int i = 0; i < SLOTS; i++) begin
      led_cfg[i] = '{mode: MODE_OFF, gap: '0};
    end
    led_cfg[0] = '{mode: MODE_TOGGLE, gap: DEFAULT_GAP0};
    for (int i = 0; i < NL; i++) begin
      countdown[i]  = '0;
      temp_gap[i]   = TEMP_GAP_RESET;
      temp_mode[i]  = MODE_TOGGLE;
      temp_count[i] = '0;
      lit[i]        = 1'b0;
    end
  endfunction

  function automatic void fire_led(int i, logic [MODE_W-1:0] mode);
    case (mode)
      MODE_OFF:    lit[i] = 1'b0;
      MODE_ON:     lit[i] = 1'b1;
      MODE_TOGGLE: lit[i] = ~lit[i];
      default: begin
        // over acts only while the temporary mode is over as well
        if (temp_mode[i] == MODE_OVER) begin
          lit[i]       = ~lit[i];
          temp_mode[i] = MODE_OFF;
        end
      end
    endcase
  endfunction

  function automatic logic [LEVELS_W-1:0] next_levels(item_t cmd);
    logic [LEVELS_W-1:0] lv;
    if (cmd.opcode == OP_LOAD) begin
      if (cmd.led_index < NL) begin
        temp_gap[cmd.led_index]   = cmd.gap_ticks;
        temp_mode[cmd.led_index]  = cmd.pattern_mode;
        temp_count[cmd.led_index] = cmd.repeat_count;
      end
    end else begin
      for (int i = 0; i < NL; i++) begin
        if (countdown[i] != '0) begin
          countdown[i] = countdown[i] - 1'b1;
        end else if (temp_count[i] == '0) begin
          fire_led(i, led_cfg[i].mode);
          countdown[i] = led_cfg[i].gap;
        end else begin
          fire_led(i, temp_mode[i]);
          countdown[i]  = temp_gap[i];
          temp_count[i] = temp_count[i] - 1'b1;
        end
      end
    end
    lv = '0;
    for (int i = 0; i < NL; i++) begin
      lv[i] = lit[i];
    end
    return lv;
  endfunction

  always @(posedge clk) begin : monitor
    item_t               cmd;
    logic [LEVELS_W-1:0] due;
    int                  idx;
    if (rst) begin
      clear_led_state();
      levels_due.delete();
      errors = 0;
    end else begin
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        if (levels_due.size() == 0) begin
          $error("led_levels: transfer with nothing expected, actual %0h", result.led_levels);
          errors++;
        end else begin
          due = levels_due.pop_front();
          if (result.led_levels !== due) begin
            $error("led_levels: expected %0h, actual %0h", due, result.led_levels);
            errors++;
          end
        end
      end
      if (item.valid === 1'b1 && item.ready === 1'b1) begin
        cmd = '{opcode: item.opcode, led_index: item.led_index, gap_ticks: item.gap_ticks,
                pattern_mode: item.pattern_mode, repeat_count: item.repeat_count};
        levels_due.push_back(next_levels(cmd));
      end
      if (psel && penable && pwrite && pready) begin
        idx = int'(paddr >> 2);
        if (idx < NUM_REGS) begin
          if (idx[0] == REG_SEL_MODE) begin
            led_cfg[idx >> 1].mode = pwdata[MODE_W-1:0];
          end else begin
            led_cfg[idx >> 1].gap = pwdata[GAP_W-1:0];
          end
        end
      end
    end
    pending = levels_due.size();
  end

endmodule

// ===== bench/led_blink_pattern_timer_top_tb.sv =====
// Top of the LED blink pattern timer bench: clock, reset, APB writes, command and
// result traffic with random idling; the verdict comes from lbpt_checker.
// Depends on lbpt_pkg, lbpt_item_if, lbpt_result_if, lbpt_checker and the block.
`timescale 1ns / 1ps

module led_blink_pattern_timer_top_tb;
  import lbpt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 205;
  localparam int LONG_HOLD    = 64;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  bit                gaps_on;
  bit                rx_stall_on;
  bit                long_hold;
  int                cycle_count;

  lbpt_item_if   item_ch ();
  lbpt_result_if result_ch ();

  led_blink_pattern_timer_top u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lbpt_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [GAP_W-1:0] pick_gap();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return GAP_W'($urandom());
      2:       return '1;
      default: return GAP_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic item_t pick_item();
    item_t cmd;
    cmd.opcode       = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_TICK;
    cmd.led_index    = INDEX_W'($urandom_range(0, 3));
    cmd.gap_ticks    = pick_gap();
    cmd.pattern_mode = MODE_W'($urandom_range(0, 3));
    cmd.repeat_count = ($urandom_range(0, 15) == 0) ? COUNT_W'($urandom_range(0, 255))
                                                    : COUNT_W'($urandom_range(0, 5));
    return cmd;
  endfunction

  task automatic send_item(item_t cmd);
    item_ch.opcode       <= cmd.opcode;
    item_ch.led_index    <= cmd.led_index;
    item_ch.gap_ticks    <= cmd.gap_ticks;
    item_ch.pattern_mode <= cmd.pattern_mode;
    item_ch.repeat_count <= cmd.repeat_count;
    item_ch.valid        <= 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic send_ticks(int n);
    item_t cmd;
    repeat (n) begin
      cmd        = pick_item();
      cmd.opcode = OP_TICK;
      send_item(cmd);
    end
  endtask

  task automatic send_load(int idx, logic [GAP_W-1:0] gap, logic [MODE_W-1:0] mode,
                           logic [COUNT_W-1:0] reps);
    item_t cmd;
    cmd = '{opcode: OP_LOAD, led_index: INDEX_W'(idx), gap_ticks: gap,
            pattern_mode: mode, repeat_count: reps};
    send_item(cmd);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(int index, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(index * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_led_cfg(int led, logic [MODE_W-1:0] mode, logic [GAP_W-1:0] gap);
    // fill unused data bits with noise
    write_reg(led * 2 + REG_SEL_MODE, ($urandom() & ~32'h3) | DATA_W'(mode));
    write_reg(led * 2 + REG_SEL_GAP, ($urandom() & 32'hFFFF_0000) | DATA_W'(gap));
  endtask

  initial begin
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst === 1'b1) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] mode;
    logic [GAP_W-1:0]  gap;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    item_ch.valid        = 1'b0;
    item_ch.opcode       = OP_TICK;
    item_ch.led_index    = '0;
    item_ch.gap_ticks    = '0;
    item_ch.pattern_mode = MODE_OFF;
    item_ch.repeat_count = '0;
    gaps_on              = 1'b1;
    rx_stall_on          = 1'b1;
    long_hold            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults, ignored index, extreme loads
    send_ticks(3);
    send_load(3, '1, MODE_OVER, 8'hFF);
    send_load(1, '0, MODE_TOGGLE, 8'hFF);
    send_load(2, 16'd1, MODE_ON, 8'd2);
    send_load(0, '0, MODE_OVER, 8'd1);
    send_ticks(5);

    // default over, with and without temporary over
    drain();
    write_led_cfg(0, MODE_OVER, '0);
    write_led_cfg(1, MODE_ON, '1);
    write_led_cfg(2, MODE_OFF, '0);
    send_ticks(2);
    send_load(0, 16'd2, MODE_OVER, 8'd0);
    send_ticks(2);
    send_load(2, '0, MODE_OVER, 8'd3);
    send_load(1, '0, MODE_OFF, 8'd0);
    send_ticks(5);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      for (int led = 0; led < SLOTS; led++) begin
        mode = (phase == 2) ? MODE_OVER : MODE_W'($urandom_range(0, 3));
        gap  = (phase == 1) ? GAP_W'(16'hFFFF) : (phase == 4) ? GAP_W'(0) : pick_gap();
        write_led_cfg(led, mode, gap);
      end
      if (phase == PHASES - 1) begin
        gaps_on     = 1'b0;
        rx_stall_on = 1'b0;
      end
      if (phase == 3) long_hold = 1'b1;
      repeat (PHASE_ITEMS) send_item(pick_item());
    end

    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
